// ----- src/ufcp_pkg.sv -----
// ----------------------------------------------------------------------------
// ufcp_pkg: shared types and constants of the unit normal block
// Holds the fixed magnitude window and the payload records that move between
// the normalizing, square root and division cells.
// ----------------------------------------------------------------------------
package ufcp_pkg;

  // Normalized magnitudes sit in [2^30, 2^31).
  localparam int NORM_W  = 31;
  localparam int WIN_MSB = 30;
  // Sum of three squared 31-bit magnitudes stays below 2^64.
  localparam int SUM_W   = 64;
  // Its integer square root stays below 2^32.
  localparam int ROOT_W  = 32;
  // Partial remainder of the square root recurrence.
  localparam int SREM_W  = 34;

  // Signs of the three cross product components and the zero flag.
  typedef struct packed {
    logic [2:0] neg;
    logic       degen;
  } ufcp_tag_t;

  // Normalized magnitudes together with their signs.
  typedef struct packed {
    logic [2:0][NORM_W-1:0] mag;
    ufcp_tag_t              tag;
  } ufcp_vec_t;

endpackage

// ----- src/ufcp_norm_cell.sv -----
// ----------------------------------------------------------------------------
// ufcp_norm_cell: one step of the magnitude window shifter
// Shifts all three magnitudes by a fixed amount when their common leading
// bit says so; a row of these cells moves the vector into the window.
// ----------------------------------------------------------------------------
module ufcp_norm_cell #(
  parameter int W     = 31,
  parameter int SHIFT = 1,
  parameter bit RIGHT = 1'b0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [2:0][W-1:0]     in_mag,
  input  ufcp_pkg::ufcp_tag_t   in_tag,
  output logic                  out_valid,
  output logic [2:0][W-1:0]     out_mag,
  output ufcp_pkg::ufcp_tag_t   out_tag
);

  localparam int RPOS = ufcp_pkg::WIN_MSB + SHIFT;
  localparam int LPOS = ufcp_pkg::WIN_MSB + 1 - SHIFT;

  logic                  valid_r;
  logic [2:0][W-1:0]     mag_r, mag_nxt;
  ufcp_pkg::ufcp_tag_t   tag_r;
  logic [W-1:0]          orv;
  logic                  take;

  // The leading bit of the OR of the three is the leading bit of the largest.
  always_comb begin
    orv = in_mag[0] | in_mag[1] | in_mag[2];
    if (RIGHT) begin
      take = |(orv >> RPOS);
    end else begin
      take = ~|(orv >> LPOS);
    end
    for (int i = 0; i < 3; i++) begin
      if (!take) begin
        mag_nxt[i] = in_mag[i];
      end else if (RIGHT) begin
        mag_nxt[i] = in_mag[i] >> SHIFT;
      end else begin
        mag_nxt[i] = in_mag[i] << SHIFT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r <= mag_nxt;
      tag_r <= in_tag;
    end
  end

  assign out_valid = valid_r;
  assign out_mag   = mag_r;
  assign out_tag   = tag_r;

endmodule

// ----- src/ufcp_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// ufcp_sqrt_cell: one root bit of the integer square root
// Takes two radicand bits, tries the next root bit and keeps the remainder.
// ----------------------------------------------------------------------------
module ufcp_sqrt_cell (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic [ufcp_pkg::SUM_W-1:0]          in_rad,
  input  logic [ufcp_pkg::SREM_W-1:0]         in_rem,
  input  logic [ufcp_pkg::ROOT_W-1:0]         in_root,
  input  ufcp_pkg::ufcp_vec_t                 in_vec,
  output logic                                out_valid,
  output logic [ufcp_pkg::SUM_W-1:0]          out_rad,
  output logic [ufcp_pkg::SREM_W-1:0]         out_rem,
  output logic [ufcp_pkg::ROOT_W-1:0]         out_root,
  output ufcp_pkg::ufcp_vec_t                 out_vec
);

  logic                                valid_r;
  logic [ufcp_pkg::SUM_W-1:0]          rad_r;
  logic [ufcp_pkg::SREM_W-1:0]         rem_r, rem_nxt, rem_sh, trial;
  logic [ufcp_pkg::ROOT_W-1:0]         root_r, root_nxt;
  ufcp_pkg::ufcp_vec_t                 vec_r;

  always_comb begin
    rem_sh = {in_rem[ufcp_pkg::SREM_W-3:0], in_rad[ufcp_pkg::SUM_W-1 -: 2]};
    trial  = {in_root, 2'b01};
    if (rem_sh >= trial) begin
      rem_nxt  = rem_sh - trial;
      root_nxt = {in_root[ufcp_pkg::ROOT_W-2:0], 1'b1};
    end else begin
      rem_nxt  = rem_sh;
      root_nxt = {in_root[ufcp_pkg::ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= in_rad << 2;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      vec_r  <= in_vec;
    end
  end

  assign out_valid = valid_r;
  assign out_rad   = rad_r;
  assign out_rem   = rem_r;
  assign out_root  = root_r;
  assign out_vec   = vec_r;

endmodule

// ----- src/ufcp_div_cell.sv -----
// ----------------------------------------------------------------------------
// ufcp_div_cell: one quotient bit for the three normal components
// Restoring division step on three lanes that share the same divisor.
// ----------------------------------------------------------------------------
module ufcp_div_cell #(
  parameter int QW = 15
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  en,
  input  logic                                  in_valid,
  input  logic [2:0][QW-1:0]                    in_low,
  input  logic [2:0][ufcp_pkg::ROOT_W-1:0]      in_rem,
  input  logic [2:0][QW-1:0]                    in_quo,
  input  logic [ufcp_pkg::ROOT_W-1:0]           in_root,
  input  ufcp_pkg::ufcp_tag_t                   in_tag,
  output logic                                  out_valid,
  output logic [2:0][QW-1:0]                    out_low,
  output logic [2:0][ufcp_pkg::ROOT_W-1:0]      out_rem,
  output logic [2:0][QW-1:0]                    out_quo,
  output logic [ufcp_pkg::ROOT_W-1:0]           out_root,
  output ufcp_pkg::ufcp_tag_t                   out_tag
);

  logic                                  valid_r;
  logic [2:0][QW-1:0]                    low_r, quo_r, quo_nxt;
  logic [2:0][ufcp_pkg::ROOT_W-1:0]      rem_r, rem_nxt;
  logic [ufcp_pkg::ROOT_W-1:0]           root_r;
  ufcp_pkg::ufcp_tag_t                   tag_r;
  logic [2:0][ufcp_pkg::ROOT_W:0]        rem_sh;
  logic [2:0]                            ge;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rem_sh[i] = {in_rem[i], in_low[i][QW-1]};
      ge[i]     = rem_sh[i] >= {1'b0, in_root};
      if (ge[i]) begin
        rem_nxt[i] = ufcp_pkg::ROOT_W'(rem_sh[i] - {1'b0, in_root});
      end else begin
        rem_nxt[i] = rem_sh[i][ufcp_pkg::ROOT_W-1:0];
      end
      quo_nxt[i] = {in_quo[i][QW-2:0], ge[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        low_r[i] <= in_low[i] << 1;
      end
      rem_r  <= rem_nxt;
      quo_r  <= quo_nxt;
      root_r <= in_root;
      tag_r  <= in_tag;
    end
  end

  assign out_valid = valid_r;
  assign out_low   = low_r;
  assign out_rem   = rem_r;
  assign out_quo   = quo_r;
  assign out_root  = root_r;
  assign out_tag   = tag_r;

endmodule

// ----- src/unit_normal_from_cross_product_top.sv -----
// ----------------------------------------------------------------------------
// unit_normal_from_cross_product_top: unit surface normal from two vectors
// Cross product, window shift, square root and division as one row of cells.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  tdata (lowest bit first)          tuser
//   in_      slave      ax, ay, az, bx, by_comp, bz       -
//   out_     master     nx, ny, nz                        degenerate
//
// One request is taken every cycle while in_tready is high; each request yields
// exactly one result. The row holds a product register, a difference register,
// right-shift cells (0 to 6, two at the default width), 5 left-shift cells,
// square and sum registers, 32 square root cells, a dividend register,
// OUT_FRAC_BITS + 1 division cells and an output register. At the default
// parameters the square root row, one root bit per cell, is its longest part.
// Reset (rst_n low, synchronous) empties every stage and the output side.
// A stalled result sits in the output register while a skid register takes
// one more; only when the skid register is full does the whole row hold and
// in_tready drop.
// ----------------------------------------------------------------------------
module unit_normal_from_cross_product_top #(
  parameter int IN_WIDTH      = 16,
  parameter int OUT_FRAC_BITS = 14
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  // ax, ay, az, bx, by_comp, bz, IN_WIDTH bits each, zero padded to bytes
  input  logic [((6*IN_WIDTH+7)/8)*8-1:0]         in_tdata,
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  // nx, ny, nz, OUT_FRAC_BITS+2 bits each, zero padded to bytes
  output logic [((3*(OUT_FRAC_BITS+2)+7)/8)*8-1:0] out_tdata,
  // degenerate
  output logic                                    out_tuser
);

  localparam int MW    = 2*IN_WIDTH + 1;
  localparam int RW    = (MW > ufcp_pkg::NORM_W) ? MW : ufcp_pkg::NORM_W;
  localparam int QW    = OUT_FRAC_BITS + 1;
  localparam int OW    = OUT_FRAC_BITS + 2;
  localparam int ODW   = ((3*OW+7)/8)*8;
  localparam int NUMW  = ufcp_pkg::NORM_W + OUT_FRAC_BITS + 1;
  localparam int NR    = 6;
  localparam int NL    = 5;
  localparam int NS    = ufcp_pkg::ROOT_W;
  localparam int RES_W = 3*OW + 1;

  // Flow control: every stage moves while the skid register is free.
  logic en;
  logic sk_v_r, out_v_r;
  logic [RES_W-1:0] sk_d_r, out_d_r;

  assign en        = ~sk_v_r;
  assign in_tready = en;

  // Input fields, sign taken from IN_WIDTH.
  logic signed [IN_WIDTH-1:0] fa_x, fa_y, fa_z, fb_x, fb_y, fb_z;

  assign fa_x = in_tdata[0*IN_WIDTH +: IN_WIDTH];
  assign fa_y = in_tdata[1*IN_WIDTH +: IN_WIDTH];
  assign fa_z = in_tdata[2*IN_WIDTH +: IN_WIDTH];
  assign fb_x = in_tdata[3*IN_WIDTH +: IN_WIDTH];
  assign fb_y = in_tdata[4*IN_WIDTH +: IN_WIDTH];
  assign fb_z = in_tdata[5*IN_WIDTH +: IN_WIDTH];

  // Stage 1: the six products of the cross product.
  logic                               v1_r;
  logic signed [5:0][2*IN_WIDTH-1:0]  prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r[0] <= fa_y * fb_z;
      prod_r[1] <= fb_y * fa_z;
      prod_r[2] <= fa_z * fb_x;
      prod_r[3] <= fb_z * fa_x;
      prod_r[4] <= fa_x * fb_y;
      prod_r[5] <= fb_x * fa_y;
    end
  end

  // Stage 2: differences as sign and magnitude; all zero marks a degenerate
  // pair.
  logic signed [2:0][MW-1:0] dif;
  logic [2:0][MW-1:0]        mag_nxt;
  ufcp_pkg::ufcp_tag_t       tag2_nxt;
  logic                      v2_r;
  logic [2:0][MW-1:0]        mag2_r;
  ufcp_pkg::ufcp_tag_t       tag2_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dif[i] = MW'($signed(prod_r[2*i])) - MW'($signed(prod_r[2*i+1]));
      tag2_nxt.neg[i] = dif[i][MW-1];
      mag_nxt[i] = dif[i][MW-1] ? MW'(-dif[i]) : MW'(dif[i]);
    end
    tag2_nxt.degen = (dif[0] == '0) && (dif[1] == '0) && (dif[2] == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag2_r <= mag_nxt;
      tag2_r <= tag2_nxt;
    end
  end

  // Right-shift row: brings wide magnitudes below 2^31, truncating.
  logic                rv   [0:NR];
  logic [2:0][RW-1:0]  rmag [0:NR];
  ufcp_pkg::ufcp_tag_t rtag [0:NR];

  assign rv[0]   = v2_r;
  assign rtag[0] = tag2_r;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rmag[0][i] = RW'(mag2_r[i]);
    end
  end

  for (genvar g = 0; g < NR; g++) begin : g_right
    localparam int SH = 32 >> g;
    if (ufcp_pkg::WIN_MSB + SH < RW) begin : g_cell
      ufcp_norm_cell #(.W(RW), .SHIFT(SH), .RIGHT(1'b1)) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (rv[g]),
        .in_mag    (rmag[g]),
        .in_tag    (rtag[g]),
        .out_valid (rv[g+1]),
        .out_mag   (rmag[g+1]),
        .out_tag   (rtag[g+1])
      );
    end else begin : g_pass
      // No magnitude can reach this shift at this input width.
      assign rv[g+1]   = rv[g];
      assign rmag[g+1] = rmag[g];
      assign rtag[g+1] = rtag[g];
    end
  end

  // Left-shift row: exact shifts until the largest magnitude reaches 2^30.
  logic                                lv   [0:NL];
  logic [2:0][ufcp_pkg::NORM_W-1:0]    lmag [0:NL];
  ufcp_pkg::ufcp_tag_t                 ltag [0:NL];

  assign lv[0]   = rv[NR];
  assign ltag[0] = rtag[NR];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lmag[0][i] = rmag[NR][i][ufcp_pkg::NORM_W-1:0];
    end
  end

  for (genvar g = 0; g < NL; g++) begin : g_left
    ufcp_norm_cell #(.W(ufcp_pkg::NORM_W), .SHIFT(16 >> g), .RIGHT(1'b0)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (lv[g]),
      .in_mag    (lmag[g]),
      .in_tag    (ltag[g]),
      .out_valid (lv[g+1]),
      .out_mag   (lmag[g+1]),
      .out_tag   (ltag[g+1])
    );
  end

  // Squares, then their sum.
  logic                                  vq_r, vs_r;
  logic [2:0][2*ufcp_pkg::NORM_W-1:0]    sq_r;
  ufcp_pkg::ufcp_vec_t                   vecq_r, vecs_r;
  logic [ufcp_pkg::SUM_W-1:0]            sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vq_r <= 1'b0;
      vs_r <= 1'b0;
    end else if (en) begin
      vq_r <= lv[NL];
      vs_r <= vq_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= lmag[NL][i] * lmag[NL][i];
      end
      vecq_r.mag <= lmag[NL];
      vecq_r.tag <= ltag[NL];
      sum_r      <= ufcp_pkg::SUM_W'(sq_r[0]) + ufcp_pkg::SUM_W'(sq_r[1])
                    + ufcp_pkg::SUM_W'(sq_r[2]);
      vecs_r     <= vecq_r;
    end
  end

  // Square root row: one root bit per cell.
  logic                           sv    [0:NS];
  logic [ufcp_pkg::SUM_W-1:0]     srad  [0:NS];
  logic [ufcp_pkg::SREM_W-1:0]    srem  [0:NS];
  logic [ufcp_pkg::ROOT_W-1:0]    sroot [0:NS];
  ufcp_pkg::ufcp_vec_t            svec  [0:NS];

  assign sv[0]    = vs_r;
  assign srad[0]  = sum_r;
  assign srem[0]  = '0;
  assign sroot[0] = '0;
  assign svec[0]  = vecs_r;

  for (genvar g = 0; g < NS; g++) begin : g_sqrt
    ufcp_sqrt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (sv[g]),
      .in_rad    (srad[g]),
      .in_rem    (srem[g]),
      .in_root   (sroot[g]),
      .in_vec    (svec[g]),
      .out_valid (sv[g+1]),
      .out_rad   (srad[g+1]),
      .out_rem   (srem[g+1]),
      .out_root  (sroot[g+1]),
      .out_vec   (svec[g+1])
    );
  end

  // Dividend: magnitude scaled by 2^OUT_FRAC_BITS plus half the root, which
  // rounds half away from zero. The quotient fits QW bits, so its upper part
  // is already a valid starting remainder.
  logic [2:0][NUMW-1:0]                num;
  logic                                vd_r;
  logic [2:0][QW-1:0]                  dlow_r;
  logic [2:0][ufcp_pkg::ROOT_W-1:0]    drem_r;
  logic [ufcp_pkg::ROOT_W-1:0]         droot_r;
  ufcp_pkg::ufcp_tag_t                 dtag_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i] = (NUMW'(svec[NS].mag[i]) << OUT_FRAC_BITS)
               + NUMW'(sroot[NS] >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
    end else if (en) begin
      vd_r <= sv[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dlow_r[i] <= num[i][QW-1:0];
        drem_r[i] <= ufcp_pkg::ROOT_W'(num[i] >> QW);
      end
      droot_r <= sroot[NS];
      dtag_r  <= svec[NS].tag;
    end
  end

  // Division row: one quotient bit per cell on all three components.
  logic                                qv    [0:QW];
  logic [2:0][QW-1:0]                  qlow  [0:QW];
  logic [2:0][ufcp_pkg::ROOT_W-1:0]    qrem  [0:QW];
  logic [2:0][QW-1:0]                  qquo  [0:QW];
  logic [ufcp_pkg::ROOT_W-1:0]         qroot [0:QW];
  ufcp_pkg::ufcp_tag_t                 qtag  [0:QW];

  assign qv[0]    = vd_r;
  assign qlow[0]  = dlow_r;
  assign qrem[0]  = drem_r;
  assign qquo[0]  = '0;
  assign qroot[0] = droot_r;
  assign qtag[0]  = dtag_r;

  for (genvar g = 0; g < QW; g++) begin : g_div
    ufcp_div_cell #(.QW(QW)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (qv[g]),
      .in_low    (qlow[g]),
      .in_rem    (qrem[g]),
      .in_quo    (qquo[g]),
      .in_root   (qroot[g]),
      .in_tag    (qtag[g]),
      .out_valid (qv[g+1]),
      .out_low   (qlow[g+1]),
      .out_rem   (qrem[g+1]),
      .out_quo   (qquo[g+1]),
      .out_root  (qroot[g+1]),
      .out_tag   (qtag[g+1])
    );
  end

  // Result: apply signs; a degenerate pair gives zeros and the flag.
  logic [RES_W-1:0] res;
  logic [OW-1:0]    qext;
  logic             prod_v;

  always_comb begin
    res = '0;
    for (int i = 0; i < 3; i++) begin
      qext = OW'(qquo[QW][i]);
      if (qtag[QW].degen) begin
        res[i*OW +: OW] = '0;
      end else if (qtag[QW].neg[i]) begin
        res[i*OW +: OW] = OW'(-qext);
      end else begin
        res[i*OW +: OW] = qext;
      end
    end
    res[RES_W-1] = qtag[QW].degen;
  end

  assign prod_v = en & qv[QW];

  // Output register with a skid register behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      sk_v_r  <= 1'b0;
    end else if (!out_v_r || out_tready) begin
      if (sk_v_r) begin
        out_v_r <= 1'b1;
        sk_v_r  <= 1'b0;
      end else begin
        out_v_r <= prod_v;
      end
    end else if (prod_v) begin
      sk_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_tready) begin
      out_d_r <= sk_v_r ? sk_d_r : res;
    end else if (prod_v) begin
      sk_d_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = ODW'(out_d_r[3*OW-1:0]);
  assign out_tuser  = out_d_r[RES_W-1];

endmodule
